FILE: sv/cdtu_pkg.sv
`default_nettype none

package cdtu_pkg;

   // Default memory address width; the memory holds 2**ADDR_WIDTH bytes.
   localparam int ADDR_WIDTH_DEF = 16;

   // Width of the microprogram counter.
   localparam int UPC_W = 5;

   // Instruction codes of the data transfer group.
   typedef enum logic [3:0] {
      OP_MOV  = 4'd0,
      OP_MVI  = 4'd1,
      OP_LDA  = 4'd2,
      OP_STA  = 4'd3,
      OP_LHLD = 4'd4,
      OP_SHLD = 4'd5,
      OP_STAX = 4'd6,
      OP_XCHG = 4'd7,
      OP_SPHL = 4'd8,
      OP_XTHL = 4'd9,
      OP_PUSH = 4'd10,
      OP_POP  = 4'd11
   } op_type;

   // Register operand codes; code M is the memory byte at HL.
   localparam logic [2:0] REG_B = 3'd0;
   localparam logic [2:0] REG_C = 3'd1;
   localparam logic [2:0] REG_D = 3'd2;
   localparam logic [2:0] REG_E = 3'd3;
   localparam logic [2:0] REG_H = 3'd4;
   localparam logic [2:0] REG_L = 3'd5;
   localparam logic [2:0] REG_M = 3'd6;
   localparam logic [2:0] REG_A = 3'd7;

   // Register pair code that names no pair.
   localparam logic [1:0] PAIR_NONE = 2'd3;

   // Slots of the seven-entry register file.
   localparam int RF_DEPTH = 7;
   localparam logic [2:0] SLOT_H = 3'd4;
   localparam logic [2:0] SLOT_L = 3'd5;
   localparam logic [2:0] SLOT_A = 3'd6;

   // One decoded instruction.
   typedef struct packed {
      logic [3:0]  op;
      logic [2:0]  dst_reg;
      logic [2:0]  src_reg;
      logic [1:0]  pair;
      logic [7:0]  imm;
      logic [15:0] addr;
   } req_type;

   // Architectural state reported after each instruction.
   typedef struct packed {
      logic [7:0]  reg_a;
      logic [7:0]  reg_b;
      logic [7:0]  reg_c;
      logic [7:0]  reg_d;
      logic [7:0]  reg_e;
      logic [7:0]  reg_h;
      logic [7:0]  reg_l;
      logic [15:0] stack_ptr_out;
   } rsp_type;

   // Memory address sources.
   typedef enum logic [2:0] {
      AS_DIRECT,
      AS_DIRECT_P1,
      AS_HL,
      AS_PAIR,
      AS_SP,
      AS_SP_P1,
      AS_SP_M1,
      AS_SP_M2
   } addr_sel_type;

   // Memory write data sources.
   typedef enum logic [2:0] {
      WD_SRC,
      WD_IMM,
      WD_A,
      WD_L,
      WD_H,
      WD_PAIR_HI,
      WD_PAIR_LO
   } wdata_sel_type;

   // Register file write targets.
   typedef enum logic [2:0] {
      RD_DST,
      RD_A,
      RD_L,
      RD_H,
      RD_PAIR_HI,
      RD_PAIR_LO
   } rdst_sel_type;

   // Register file write data sources.
   typedef enum logic [1:0] {
      RS_MEM,
      RS_SRC,
      RS_IMM
   } rsrc_sel_type;

   // Stack pointer operations.
   typedef enum logic [1:0] {
      SP_HOLD,
      SP_LOAD_HL,
      SP_DEC2,
      SP_INC2
   } sp_op_type;

   // Jump conditions.
   typedef enum logic {
      CD_NONE,
      CD_PAIR_BAD
   } cond_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // One control word of the microprogram.
   typedef struct packed {
      cond_type          cond;
      logic [UPC_W-1:0]  target;
      logic              last;
      logic              mem_rd;
      logic              mem_wr;
      addr_sel_type      addr_sel;
      wdata_sel_type     wdata_sel;
      logic              rf_we;
      rdst_sel_type      rdst_sel;
      rsrc_sel_type      rsrc_sel;
      logic              xchg;
      sp_op_type         sp_op;
   } uword_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic      clr;
      logic      load;
      uword_type uw;
   } ctrl_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic clr_last;
      logic pair_bad;
   } status_type;

   // Control word that does nothing.
   localparam uword_type UW_NOP = '{
      cond:      CD_NONE,
      target:    '0,
      last:      1'b0,
      mem_rd:    1'b0,
      mem_wr:    1'b0,
      addr_sel:  AS_DIRECT,
      wdata_sel: WD_SRC,
      rf_we:     1'b0,
      rdst_sel:  RD_DST,
      rsrc_sel:  RS_MEM,
      xchg:      1'b0,
      sp_op:     SP_HOLD
   };

   // Entry points of the microprogram.
   localparam logic [UPC_W-1:0] UA_MOV_RR = 5'd0;
   localparam logic [UPC_W-1:0] UA_MOV_WM = 5'd1;
   localparam logic [UPC_W-1:0] UA_MOV_RM = 5'd2;
   localparam logic [UPC_W-1:0] UA_MVI_R  = 5'd4;
   localparam logic [UPC_W-1:0] UA_MVI_M  = 5'd5;
   localparam logic [UPC_W-1:0] UA_LDA    = 5'd6;
   localparam logic [UPC_W-1:0] UA_STA    = 5'd8;
   localparam logic [UPC_W-1:0] UA_LHLD   = 5'd9;
   localparam logic [UPC_W-1:0] UA_SHLD   = 5'd12;
   localparam logic [UPC_W-1:0] UA_STAX   = 5'd14;
   localparam logic [UPC_W-1:0] UA_XCHG   = 5'd16;
   localparam logic [UPC_W-1:0] UA_SPHL   = 5'd17;
   localparam logic [UPC_W-1:0] UA_XTHL   = 5'd18;
   localparam logic [UPC_W-1:0] UA_PUSH   = 5'd22;
   localparam logic [UPC_W-1:0] UA_POP    = 5'd25;
   localparam logic [UPC_W-1:0] UA_NOP    = 5'd29;

   // Maps a register operand code to its register file slot.
   function automatic logic [2:0] rf_slot(input logic [2:0] code);
      rf_slot = (code == REG_A) ? SLOT_A : code;
   endfunction

   // Dispatch table: picks the microprogram entry for an instruction.
   function automatic logic [UPC_W-1:0] dispatch(input req_type req);
      logic dst_m;
      logic src_m;
      dst_m = (req.dst_reg == REG_M);
      src_m = (req.src_reg == REG_M);
      case (req.op)
         OP_MOV: begin
            if (dst_m && src_m) begin
               dispatch = UA_NOP;
            end else if (dst_m) begin
               dispatch = UA_MOV_WM;
            end else if (src_m) begin
               dispatch = UA_MOV_RM;
            end else begin
               dispatch = UA_MOV_RR;
            end
         end
         OP_MVI:  dispatch = dst_m ? UA_MVI_M : UA_MVI_R;
         OP_LDA:  dispatch = UA_LDA;
         OP_STA:  dispatch = UA_STA;
         OP_LHLD: dispatch = UA_LHLD;
         OP_SHLD: dispatch = UA_SHLD;
         OP_STAX: dispatch = UA_STAX;
         OP_XCHG: dispatch = UA_XCHG;
         OP_SPHL: dispatch = UA_SPHL;
         OP_XTHL: dispatch = UA_XTHL;
         OP_PUSH: dispatch = UA_PUSH;
         OP_POP:  dispatch = UA_POP;
         default: dispatch = UA_NOP;
      endcase
   endfunction

   // The microprogram. A read issued in one step returns its byte in the next.
   function automatic uword_type ucode_rom(input logic [UPC_W-1:0] upc);
      uword_type w;
      w = UW_NOP;
      case (upc)
         // MOV r,r
         5'd0: begin
            w.rf_we = 1'b1; w.rdst_sel = RD_DST; w.rsrc_sel = RS_SRC; w.last = 1'b1;
         end
         // MOV M,r
         5'd1: begin
            w.mem_wr = 1'b1; w.addr_sel = AS_HL; w.wdata_sel = WD_SRC; w.last = 1'b1;
         end
         // MOV r,M
         5'd2: begin
            w.mem_rd = 1'b1; w.addr_sel = AS_HL;
         end
         5'd3: begin
            w.rf_we = 1'b1; w.rdst_sel = RD_DST; w.rsrc_sel = RS_MEM; w.last = 1'b1;
         end
         // MVI r
         5'd4: begin
            w.rf_we = 1'b1; w.rdst_sel = RD_DST; w.rsrc_sel = RS_IMM; w.last = 1'b1;
         end
         // MVI M
         5'd5: begin
            w.mem_wr = 1'b1; w.addr_sel = AS_HL; w.wdata_sel = WD_IMM; w.last = 1'b1;
         end
         // LDA
         5'd6: begin
            w.mem_rd = 1'b1; w.addr_sel = AS_DIRECT;
         end
         5'd7: begin
            w.rf_we = 1'b1; w.rdst_sel = RD_A; w.rsrc_sel = RS_MEM; w.last = 1'b1;
         end
         // STA
         5'd8: begin
            w.mem_wr = 1'b1; w.addr_sel = AS_DIRECT; w.wdata_sel = WD_A; w.last = 1'b1;
         end
         // LHLD
         5'd9: begin
            w.mem_rd = 1'b1; w.addr_sel = AS_DIRECT;
         end
         5'd10: begin
            w.rf_we = 1'b1; w.rdst_sel = RD_L; w.rsrc_sel = RS_MEM;
            w.mem_rd = 1'b1; w.addr_sel = AS_DIRECT_P1;
         end
         5'd11: begin
            w.rf_we = 1'b1; w.rdst_sel = RD_H; w.rsrc_sel = RS_MEM; w.last = 1'b1;
         end
         // SHLD
         5'd12: begin
            w.mem_wr = 1'b1; w.addr_sel = AS_DIRECT; w.wdata_sel = WD_L;
         end
         5'd13: begin
            w.mem_wr = 1'b1; w.addr_sel = AS_DIRECT_P1; w.wdata_sel = WD_H;
            w.last = 1'b1;
         end
         // STAX
         5'd14: begin
            w.cond = CD_PAIR_BAD; w.target = UA_NOP;
         end
         5'd15: begin
            w.mem_wr = 1'b1; w.addr_sel = AS_PAIR; w.wdata_sel = WD_A; w.last = 1'b1;
         end
         // XCHG
         5'd16: begin
            w.xchg = 1'b1; w.last = 1'b1;
         end
         // SPHL
         5'd17: begin
            w.sp_op = SP_LOAD_HL; w.last = 1'b1;
         end
         // XTHL
         5'd18: begin
            w.mem_rd = 1'b1; w.addr_sel = AS_SP;
         end
         5'd19: begin
            w.mem_wr = 1'b1; w.addr_sel = AS_SP; w.wdata_sel = WD_L;
            w.rf_we = 1'b1; w.rdst_sel = RD_L; w.rsrc_sel = RS_MEM;
         end
         5'd20: begin
            w.mem_rd = 1'b1; w.addr_sel = AS_SP_P1;
         end
         5'd21: begin
            w.mem_wr = 1'b1; w.addr_sel = AS_SP_P1; w.wdata_sel = WD_H;
            w.rf_we = 1'b1; w.rdst_sel = RD_H; w.rsrc_sel = RS_MEM; w.last = 1'b1;
         end
         // PUSH
         5'd22: begin
            w.cond = CD_PAIR_BAD; w.target = UA_NOP;
         end
         5'd23: begin
            w.mem_wr = 1'b1; w.addr_sel = AS_SP_M1; w.wdata_sel = WD_PAIR_HI;
         end
         5'd24: begin
            w.mem_wr = 1'b1; w.addr_sel = AS_SP_M2; w.wdata_sel = WD_PAIR_LO;
            w.sp_op = SP_DEC2; w.last = 1'b1;
         end
         // POP
         5'd25: begin
            w.cond = CD_PAIR_BAD; w.target = UA_NOP;
         end
         5'd26: begin
            w.mem_rd = 1'b1; w.addr_sel = AS_SP;
         end
         5'd27: begin
            w.rf_we = 1'b1; w.rdst_sel = RD_PAIR_LO; w.rsrc_sel = RS_MEM;
            w.mem_rd = 1'b1; w.addr_sel = AS_SP_P1;
         end
         5'd28: begin
            w.rf_we = 1'b1; w.rdst_sel = RD_PAIR_HI; w.rsrc_sel = RS_MEM;
            w.sp_op = SP_INC2; w.last = 1'b1;
         end
         // Instruction with no effect
         5'd29: begin
            w.last = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      ucode_rom = w;
   endfunction

endpackage

`default_nettype wire

FILE: sv/cdtu_memory.sv
`default_nettype none

module cdtu_memory
   import cdtu_pkg::*;
#(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  mem_we,
   input  wire logic [ADDR_WIDTH-1:0] mem_addr,
   input  wire logic [7:0]            mem_wdata,
   output logic      [7:0]            mem_rdata
);

   localparam int DEPTH = 1 << ADDR_WIDTH;

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rdata_ff;

   // Single port byte memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem_ff[mem_addr];
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/cdtu_sequencer.sv
`default_nettype none

module cdtu_sequencer
   import cdtu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire req_type    req_data,
   input  wire status_type status,
   output logic            busy,
   output logic            rsp_strobe,
   output ctrl_type        ctrl
);

   seq_state_type    state_ff, state_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             done_ff, done_in;
   uword_type        uw;
   logic             take_jump;

   // Current control word from the microprogram.
   assign uw        = ucode_rom(upc_ff);
   assign take_jump = (uw.cond == CD_PAIR_BAD) && status.pair_bad;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_CLEAR: begin
            if (status.clr_last) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (uw.last) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_CLEAR;
         end
      endcase
   end

   // Outputs, step counter and completion strobe.
   always_comb begin
      busy      = 1'b1;
      ctrl.clr  = 1'b0;
      ctrl.load = 1'b0;
      ctrl.uw   = UW_NOP;
      upc_in    = upc_ff;
      done_in   = 1'b0;
      case (state_ff)
         SEQ_CLEAR: begin
            ctrl.clr = 1'b1;
         end
         SEQ_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.load = 1'b1;
               upc_in    = dispatch(req_data);
            end
         end
         SEQ_RUN: begin
            ctrl.uw = uw;
            upc_in  = take_jump ? uw.target : upc_ff + UPC_W'(1);
            done_in = uw.last;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_CLEAR;
         upc_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         upc_ff   <= upc_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_strobe = done_ff;

endmodule

`default_nettype wire

FILE: sv/cdtu_datapath.sv
`default_nettype none

module cdtu_datapath
   import cdtu_pkg::*;
#(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_type              ctrl,
   input  wire req_type               req_data,
   input  wire logic [7:0]            mem_rdata,
   output logic                       mem_we,
   output logic      [ADDR_WIDTH-1:0] mem_addr,
   output logic      [7:0]            mem_wdata,
   output status_type                 status,
   output rsp_type                    rsp_data
);

   req_type               req_ff, req_in;
   logic [7:0]            rf_ff [RF_DEPTH];
   logic [7:0]            rf_in [RF_DEPTH];
   logic [15:0]           sp_ff, sp_in;
   logic [ADDR_WIDTH-1:0] clr_cnt_ff, clr_cnt_in;

   logic [1:0]  pair_idx;
   logic [2:0]  hi_slot;
   logic [2:0]  lo_slot;
   logic [2:0]  dst_slot;
   logic [7:0]  src_val;
   logic [15:0] hl_val;
   logic [15:0] pair_val;
   logic [15:0] addr_full;
   logic [7:0]  wd_val;
   logic [2:0]  wr_slot;
   logic [7:0]  wr_val;

   // Operand decode; an unused pair code falls back to BC and is never written.
   assign status.pair_bad = (req_ff.pair == PAIR_NONE);
   assign pair_idx        = status.pair_bad ? 2'd0 : req_ff.pair;
   assign hi_slot         = {pair_idx, 1'b0};
   assign lo_slot         = {pair_idx, 1'b1};
   assign dst_slot        = rf_slot(req_ff.dst_reg);
   assign src_val         = rf_ff[rf_slot(req_ff.src_reg)];
   assign hl_val          = {rf_ff[SLOT_H], rf_ff[SLOT_L]};
   assign pair_val        = {rf_ff[hi_slot], rf_ff[lo_slot]};

   // Memory address select; addresses wrap at the memory size.
   always_comb begin
      case (ctrl.uw.addr_sel)
         AS_DIRECT:    addr_full = req_ff.addr;
         AS_DIRECT_P1: addr_full = req_ff.addr + 16'd1;
         AS_HL:        addr_full = hl_val;
         AS_PAIR:      addr_full = pair_val;
         AS_SP:        addr_full = sp_ff;
         AS_SP_P1:     addr_full = sp_ff + 16'd1;
         AS_SP_M1:     addr_full = sp_ff - 16'd1;
         AS_SP_M2:     addr_full = sp_ff - 16'd2;
         default:      addr_full = sp_ff;
      endcase
   end

   // Memory write data select.
   always_comb begin
      case (ctrl.uw.wdata_sel)
         WD_SRC:     wd_val = src_val;
         WD_IMM:     wd_val = req_ff.imm;
         WD_A:       wd_val = rf_ff[SLOT_A];
         WD_L:       wd_val = rf_ff[SLOT_L];
         WD_H:       wd_val = rf_ff[SLOT_H];
         WD_PAIR_HI: wd_val = rf_ff[hi_slot];
         WD_PAIR_LO: wd_val = rf_ff[lo_slot];
         default:    wd_val = src_val;
      endcase
   end

   // The clearing pass after reset writes zero through the whole memory.
   assign mem_we    = ctrl.clr | ctrl.uw.mem_wr;
   assign mem_addr  = ctrl.clr ? clr_cnt_ff : addr_full[ADDR_WIDTH-1:0];
   assign mem_wdata = ctrl.clr ? 8'd0 : wd_val;

   assign clr_cnt_in      = ctrl.clr ? clr_cnt_ff + ADDR_WIDTH'(1) : clr_cnt_ff;
   assign status.clr_last = &clr_cnt_ff;

   // Register file write target and data.
   always_comb begin
      case (ctrl.uw.rdst_sel)
         RD_DST:     wr_slot = dst_slot;
         RD_A:       wr_slot = SLOT_A;
         RD_L:       wr_slot = SLOT_L;
         RD_H:       wr_slot = SLOT_H;
         RD_PAIR_HI: wr_slot = hi_slot;
         RD_PAIR_LO: wr_slot = lo_slot;
         default:    wr_slot = dst_slot;
      endcase
      case (ctrl.uw.rsrc_sel)
         RS_MEM:  wr_val = mem_rdata;
         RS_SRC:  wr_val = src_val;
         RS_IMM:  wr_val = req_ff.imm;
         default: wr_val = mem_rdata;
      endcase
   end

   // Register file update, including the DE/HL exchange.
   always_comb begin
      rf_in = rf_ff;
      if (ctrl.uw.rf_we) begin
         rf_in[wr_slot] = wr_val;
      end
      if (ctrl.uw.xchg) begin
         rf_in[REG_D] = rf_ff[SLOT_H];
         rf_in[REG_E] = rf_ff[SLOT_L];
         rf_in[SLOT_H] = rf_ff[REG_D];
         rf_in[SLOT_L] = rf_ff[REG_E];
      end
   end

   // Stack pointer update.
   always_comb begin
      case (ctrl.uw.sp_op)
         SP_HOLD:    sp_in = sp_ff;
         SP_LOAD_HL: sp_in = hl_val;
         SP_DEC2:    sp_in = sp_ff - 16'd2;
         SP_INC2:    sp_in = sp_ff + 16'd2;
         default:    sp_in = sp_ff;
      endcase
   end

   // Instruction register is loaded on each accepted transfer.
   assign req_in = ctrl.load ? req_data : req_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_ff      <= '{default: '0};
         sp_ff      <= '0;
         clr_cnt_ff <= '0;
      end else begin
         rf_ff      <= rf_in;
         sp_ff      <= sp_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Result transfer reports the architectural registers.
   assign rsp_data.reg_a         = rf_ff[SLOT_A];
   assign rsp_data.reg_b         = rf_ff[REG_B];
   assign rsp_data.reg_c         = rf_ff[REG_C];
   assign rsp_data.reg_d         = rf_ff[REG_D];
   assign rsp_data.reg_e         = rf_ff[REG_E];
   assign rsp_data.reg_h         = rf_ff[SLOT_H];
   assign rsp_data.reg_l         = rf_ff[SLOT_L];
   assign rsp_data.stack_ptr_out = sp_ff;

endmodule

`default_nettype wire

FILE: sv/cpu_data_transfer_unit_top.sv
// Data transfer unit of an 8-bit CPU. An instruction transfer is taken on a
// clock edge where start is high and busy is low; busy then stays high while
// the microprogram runs, one control word per cycle, through a single-port
// memory whose read data is registered and arrives in the cycle after the
// read. The result transfer appears on the cycle after the last control
// word, marked by rsp_strobe for exactly one cycle; the receiver cannot
// stall it, so it must take every result on that cycle. busy is low during
// the strobe cycle, and a new instruction may be started then. The time
// from start to result strobe is shortest for XCHG, SPHL, STA, and MOV and
// MVI without a memory read, and longest for XTHL and POP. After reset the
// memory is cleared to zero, one byte per cycle, and busy stays high until
// the whole memory is clear.
`default_nettype none

module cpu_data_transfer_unit_top
   import cdtu_pkg::*;
#(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   ctrl_type              ctrl;
   status_type            status;
   logic                  mem_we;
   logic [ADDR_WIDTH-1:0] mem_addr;
   logic [7:0]            mem_wdata;
   logic [7:0]            mem_rdata;

   // Step counter, microprogram and handshake control.
   cdtu_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctrl       (ctrl)
   );

   // Register file, stack pointer and address and data selection.
   cdtu_datapath #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_data  (req_data),
      .mem_rdata (mem_rdata),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   // Byte memory.
   cdtu_memory #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_memory (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import cdtu_pkg::*;

   // Register pair codes and the highest opcode the field can carry.
   localparam logic [1:0] PAIR_BC = 2'd0;
   localparam logic [1:0] PAIR_DE = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [3:0] OP_CODE_MAX = 4'hF;

   localparam int RANDOM_INSTRS = 530;
   localparam int STEADY_FIRST = 250;
   localparam int STEADY_LAST = 400;
   localparam int DRAIN_CYCLES = 12;
   // The memory clear after reset runs through all 65536 bytes with nothing accepted.
   localparam int STALL_LIMIT = 4 * 65536;

   // Tracks the architectural state and the register snapshots still owed.
   class cpu_state_predictor;
      bit [7:0]  regs [RF_DEPTH];
      bit [15:0] sp;
      bit [7:0]  mem [65536];
      rsp_type   expected_regs_q [$];
      int        mismatches;
      int        checked;
      int        accepted;
      int        no_effect_count;
      int        stack_op_count;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         sp = '0;
         mismatches = 0;
         checked = 0;
         accepted = 0;
         no_effect_count = 0;
         stack_op_count = 0;
      endfunction

      // Register code A lives in its own slot; the others index directly.
      function bit [2:0] slot(input logic [2:0] code);
         return (code == REG_A) ? SLOT_A : code;
      endfunction

      function bit [15:0] hl_addr();
         return {regs[SLOT_H], regs[SLOT_L]};
      endfunction

      // Executes one accepted instruction transfer and queues the snapshot.
      function void note_instr(input req_type r);
         bit [7:0]  t;
         bit [15:0] a;
         bit [2:0]  hi_s;
         bit [2:0]  lo_s;
         rsp_type   e;
         hi_s = {r.pair, 1'b0};
         lo_s = {r.pair, 1'b1};
         accepted++;
         case (r.op)
            OP_MOV: begin
               if (r.dst_reg == REG_M && r.src_reg == REG_M) begin
                  no_effect_count++;
               end else if (r.dst_reg == REG_M) begin
                  mem[hl_addr()] = regs[slot(r.src_reg)];
               end else if (r.src_reg == REG_M) begin
                  regs[slot(r.dst_reg)] = mem[hl_addr()];
               end else begin
                  regs[slot(r.dst_reg)] = regs[slot(r.src_reg)];
               end
            end
            OP_MVI: begin
               if (r.dst_reg == REG_M) begin
                  mem[hl_addr()] = r.imm;
               end else begin
                  regs[slot(r.dst_reg)] = r.imm;
               end
            end
            OP_LDA: regs[SLOT_A] = mem[r.addr];
            OP_STA: mem[r.addr] = regs[SLOT_A];
            OP_LHLD: begin
               a = r.addr + 16'd1;
               regs[SLOT_L] = mem[r.addr];
               regs[SLOT_H] = mem[a];
            end
            OP_SHLD: begin
               a = r.addr + 16'd1;
               mem[r.addr] = regs[SLOT_L];
               mem[a] = regs[SLOT_H];
            end
            OP_STAX: begin
               if (r.pair == PAIR_NONE) begin
                  no_effect_count++;
               end else begin
                  mem[{regs[hi_s], regs[lo_s]}] = regs[SLOT_A];
               end
            end
            OP_XCHG: begin
               t = regs[REG_D];
               regs[REG_D] = regs[SLOT_H];
               regs[SLOT_H] = t;
               t = regs[REG_E];
               regs[REG_E] = regs[SLOT_L];
               regs[SLOT_L] = t;
            end
            OP_SPHL: sp = hl_addr();
            OP_XTHL: begin
               a = sp + 16'd1;
               t = mem[sp];
               mem[sp] = regs[SLOT_L];
               regs[SLOT_L] = t;
               t = mem[a];
               mem[a] = regs[SLOT_H];
               regs[SLOT_H] = t;
               stack_op_count++;
            end
            OP_PUSH: begin
               if (r.pair == PAIR_NONE) begin
                  no_effect_count++;
               end else begin
                  a = sp - 16'd1;
                  mem[a] = regs[hi_s];
                  a = sp - 16'd2;
                  mem[a] = regs[lo_s];
                  sp = sp - 16'd2;
                  stack_op_count++;
               end
            end
            OP_POP: begin
               if (r.pair == PAIR_NONE) begin
                  no_effect_count++;
               end else begin
                  a = sp + 16'd1;
                  regs[lo_s] = mem[sp];
                  regs[hi_s] = mem[a];
                  sp = sp + 16'd2;
                  stack_op_count++;
               end
            end
            default: no_effect_count++;
         endcase
         e.reg_a = regs[SLOT_A];
         e.reg_b = regs[REG_B];
         e.reg_c = regs[REG_C];
         e.reg_d = regs[REG_D];
         e.reg_e = regs[REG_E];
         e.reg_h = regs[SLOT_H];
         e.reg_l = regs[SLOT_L];
         e.stack_ptr_out = sp;
         expected_regs_q.push_back(e);
      endfunction

      function void compare_field(input string name, input logic [15:0] exp_val,
                                  input logic [15:0] act_val);
         if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
            mismatches++;
         end
      endfunction

      // Checks one result transfer against the oldest owed snapshot.
      function void check_regs(input rsp_type got);
         rsp_type e;
         if (expected_regs_q.size() == 0) begin
            $display("%0t: result with no instruction outstanding, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         e = expected_regs_q.pop_front();
         checked++;
         compare_field("reg_a", 16'(e.reg_a), 16'(got.reg_a));
         compare_field("reg_b", 16'(e.reg_b), 16'(got.reg_b));
         compare_field("reg_c", 16'(e.reg_c), 16'(got.reg_c));
         compare_field("reg_d", 16'(e.reg_d), 16'(got.reg_d));
         compare_field("reg_e", 16'(e.reg_e), 16'(got.reg_e));
         compare_field("reg_h", 16'(e.reg_h), 16'(got.reg_h));
         compare_field("reg_l", 16'(e.reg_l), 16'(got.reg_l));
         compare_field("stack_ptr_out", e.stack_ptr_out, got.stack_ptr_out);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   cpu_state_predictor predictor = new();
   int stall_cycles = 0;

   cpu_data_transfer_unit_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Observe both channels and watch for a hung block.
   always @(posedge clock) begin
      if (!reset && start && busy === 1'b0) begin
         predictor.note_instr(req_data);
         stall_cycles = 0;
      end else if (rsp_strobe === 1'b1) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (!reset && rsp_strobe === 1'b1) begin
         predictor.check_regs(rsp_data);
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("** cpu_data_transfer_unit_top: FAILED **");
         $finish;
      end
   end

   function automatic req_type make_instr(input logic [3:0] op, input logic [2:0] dst,
                                          input logic [2:0] src, input logic [1:0] pair,
                                          input logic [7:0] imm, input logic [15:0] addr);
      req_type r;
      r.op = op;
      r.dst_reg = dst;
      r.src_reg = src;
      r.pair = pair;
      r.imm = imm;
      r.addr = addr;
      return r;
   endfunction

   function automatic bit has_no_effect(input req_type r);
      if (r.op > OP_POP) begin
         return 1'b1;
      end
      if (r.op == OP_MOV && r.dst_reg == REG_M && r.src_reg == REG_M) begin
         return 1'b1;
      end
      return (r.op == OP_STAX || r.op == OP_PUSH || r.op == OP_POP) &&
             r.pair == PAIR_NONE;
   endfunction

   // Bytes lean toward the extremes so that HL and SP land near the wrap.
   function automatic logic [7:0] pick_byte();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         return 8'h00;
      end else if (roll < 20) begin
         return 8'hFF;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Direct addresses mostly hit two small windows so reads find written data.
   function automatic logic [15:0] pick_addr();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         return 16'($urandom_range(0, 31));
      end else if (roll < 65) begin
         return 16'hFFE0 + 16'($urandom_range(0, 31));
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   // Mostly valid instructions with random content; a few with no effect.
   function automatic req_type random_instr(input bit noisy);
      req_type r;
      int unsigned roll;
      r = make_instr(4'($urandom_range(OP_MOV, OP_POP)), 3'($urandom_range(0, 7)),
                     3'($urandom_range(0, 7)), 2'($urandom_range(PAIR_BC, PAIR_HL)),
                     pick_byte(), pick_addr());
      roll = $urandom_range(0, 99);
      if (noisy) begin
         if (roll < 40) begin
            r.op = 4'($urandom_range(OP_POP + 1, OP_CODE_MAX));
         end else if (roll < 80) begin
            case ($urandom_range(0, 2))
               0: r.op = OP_STAX;
               1: r.op = OP_PUSH;
               default: r.op = OP_POP;
            endcase
            r.pair = PAIR_NONE;
         end else begin
            r.op = OP_MOV;
            r.dst_reg = REG_M;
            r.src_reg = REG_M;
         end
      end else if (roll < 25) begin
         r.op = OP_MVI;
      end
      return r;
   endfunction

   // Present one instruction and hold it until the block takes the transfer.
   task automatic issue(input req_type instr);
      start <= 1'b1;
      req_data <= instr;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Leave the input idle for a few cycles with junk on the payload.
   task automatic pause(input int cycles);
      bit [35:0] junk;
      junk = 36'({$urandom, $urandom});
      start <= 1'b0;
      req_data <= junk;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      req_type directed_q [$];
      req_type instr;
      int      effective;
      bit      steady;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every instruction, wraps and the no-effect cases.
      directed_q.push_back(make_instr(OP_MVI, REG_A, REG_B, PAIR_BC, 8'h5A, 16'h0000));
      directed_q.push_back(make_instr(OP_MVI, REG_B, REG_B, PAIR_BC, 8'hFF, 16'h0000));
      directed_q.push_back(make_instr(OP_MVI, REG_D, REG_B, PAIR_BC, 8'h80, 16'h0000));
      directed_q.push_back(make_instr(OP_MVI, REG_H, REG_B, PAIR_BC, 8'hFF, 16'h0000));
      directed_q.push_back(make_instr(OP_MVI, REG_L, REG_B, PAIR_BC, 8'hFF, 16'h0000));
      directed_q.push_back(make_instr(OP_PUSH, REG_B, REG_B, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_PUSH, REG_B, REG_B, PAIR_NONE, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_POP, REG_B, REG_B, PAIR_NONE, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_POP, REG_B, REG_B, PAIR_DE, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_MVI, REG_M, REG_B, PAIR_BC, 8'hA5, 16'h0000));
      directed_q.push_back(make_instr(OP_MOV, REG_B, REG_M, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_MOV, REG_M, REG_M, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_MOV, REG_M, REG_A, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_MOV, REG_E, REG_B, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_STA, REG_B, REG_B, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_LHLD, REG_B, REG_B, PAIR_BC, 8'h00, 16'hFFFF));
      directed_q.push_back(make_instr(OP_SHLD, REG_B, REG_B, PAIR_BC, 8'h00, 16'hFFFF));
      directed_q.push_back(make_instr(OP_LDA, REG_B, REG_B, PAIR_BC, 8'h00, 16'hFFFF));
      directed_q.push_back(make_instr(OP_STAX, REG_B, REG_B, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_STAX, REG_B, REG_B, PAIR_HL, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_STAX, REG_B, REG_B, PAIR_NONE, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_XCHG, REG_B, REG_B, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_XCHG, REG_B, REG_B, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_SPHL, REG_B, REG_B, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_XTHL, REG_B, REG_B, PAIR_BC, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_PUSH, REG_B, REG_B, PAIR_HL, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_POP, REG_B, REG_B, PAIR_HL, 8'h00, 16'h0000));
      directed_q.push_back(make_instr(OP_CODE_MAX, REG_A, REG_A, PAIR_NONE, 8'hFF,
                                      16'hFFFF));
      foreach (directed_q[i]) begin
         issue(directed_q[i]);
         if ($urandom_range(0, 99) < 27) begin
            pause($urandom_range(1, 4));
         end
      end

      // Random: mostly effective instructions, a steady stretch in the middle.
      effective = 0;
      while (effective < RANDOM_INSTRS) begin
         instr = random_instr($urandom_range(0, 99) < 8);
         if (!has_no_effect(instr)) begin
            effective++;
         end
         issue(instr);
         steady = effective >= STEADY_FIRST && effective < STEADY_LAST;
         if (!steady && $urandom_range(0, 99) < 27) begin
            pause($urandom_range(1, 4));
         end
      end
      start <= 1'b0;

      // Drain: every owed snapshot, then a few cycles to catch strays.
      while (predictor.expected_regs_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Executed %0d instruction transfers, %0d with no effect, %0d stack accesses;",
               predictor.accepted, predictor.no_effect_count, predictor.stack_op_count);
      $display("compared %0d register snapshots, %0d mismatches.",
               predictor.checked, predictor.mismatches);
      if (predictor.mismatches == 0 && predictor.expected_regs_q.size() == 0) begin
         $display("** cpu_data_transfer_unit_top: PASSED **");
      end else begin
         $display("** cpu_data_transfer_unit_top: FAILED **");
      end
      $finish;
   end

endmodule
